// ----- sv/ofsl_pkg.sv -----
// types, header codes and defaults shared by the object file section loader
// no dependencies
`default_nettype none

package ofsl_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;

  localparam logic [15:0] HDR_CODE = 16'hCADE;
  localparam logic [15:0] HDR_DATA = 16'hDADA;
  localparam logic [15:0] HDR_SYMB = 16'hC3B7;
  localparam logic [15:0] HDR_FILE = 16'hF17E;
  localparam logic [15:0] HDR_LINE = 16'h715E;

  // number of words in a line-number record after its header
  localparam logic [1:0] LINE_REC_WORDS = 2'd3;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_ADDR    = 4'd1,
    PH_COUNT   = 4'd2,
    PH_PAYLOAD = 4'd3,
    PH_BYTES   = 4'd4,
    PH_RECORD  = 4'd5
  } phase_t;

  typedef enum logic [2:0] {
    SK_CODE = 3'd0,
    SK_DATA = 3'd1,
    SK_SYMB = 3'd2,
    SK_FILE = 3'd3,
    SK_LINE = 3'd4
  } section_t;

  typedef enum logic [1:0] {
    KIND_CODE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [15:0] mem_addr;
    logic [15:0] mem_word;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/object_file_section_loader.sv -----
// object file section loader top level
// depends on ofsl_pkg, ofsl_in_reg, ofsl_parser, ofsl_out_reg
`default_nettype none

// Loads an object file given one byte per transfer on the input channel.
// Bytes pair into big-endian words; code and data sections turn each payload
// word into one memory write transfer (kind code or data, word address, word),
// symbol, filename and line-number sections are skipped silently, and an
// unknown header word gives one error transfer carrying that word with
// address zero. One byte is taken every clock cycle, sustained, as long as
// the output side is not stalled: the parser state (phase, held high byte,
// count, address) updates once per byte, combinationally between the input
// register and the result register; a byte that causes a write reaches the
// output through both registers. Write addresses are kept to ADDR_BITS bits
// and wrap; a section count of zero means an empty section.

module object_file_section_loader #(
  parameter int unsigned ADDR_BITS = ofsl_pkg::ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ofsl_pkg::kind_t  kind,
  output logic [15:0]      mem_addr,
  output logic [15:0]      mem_word
);

  import ofsl_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       out_free;
  logic       step;
  result_t    res;

  // the parser advances whenever a byte is held and the result slot can take
  // whatever this byte produces
  assign step = byte_valid && out_free;

  ofsl_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  ofsl_parser #(
    .ADDR_BITS (ADDR_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .byte_in (byte_q),
    .res     (res)
  );

  // result register: refills in the same cycle its transfer completes
  ofsl_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .mem_addr  (mem_addr),
    .mem_word  (mem_word)
  );

endmodule

`default_nettype wire

// ----- sv/ofsl_in_reg.sv -----
// input register stage for the byte stream
// depends on nothing but the handshake of the parser behind it
`default_nettype none

module ofsl_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       take,
  output logic            byte_valid,
  output logic [7:0]      byte_q
);

  logic load;

  assign in_stall = byte_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (load) begin
      byte_valid <= 1'b1;
    end else if (take) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_q <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ofsl_parser.sv -----
// section parser: word pairing, header decode, counters and write address
// depends on ofsl_pkg
`default_nettype none

module ofsl_parser #(
  parameter int unsigned ADDR_BITS = ofsl_pkg::ADDR_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  output ofsl_pkg::result_t res
);

  import ofsl_pkg::*;

  phase_t                 parse_phase, parse_phase_next;
  logic                   byte_half, byte_half_next;
  logic [7:0]             high_byte, high_byte_next;
  section_t               section_kind, section_kind_next;
  logic [ADDR_BITS-1:0]   write_addr, write_addr_next;
  logic [15:0]            items_left, items_left_next;
  logic [1:0]             record_field, record_field_next;

  logic [15:0]            word;
  logic [15:0]            items_dec;
  logic [1:0]             field_inc;

  assign word      = {high_byte, byte_in};
  assign items_dec = items_left - 16'd1;
  assign field_inc = record_field + 2'd1;

  always_comb begin
    parse_phase_next  = parse_phase;
    byte_half_next    = byte_half;
    high_byte_next    = high_byte;
    section_kind_next = section_kind;
    write_addr_next   = write_addr;
    items_left_next   = items_left;
    record_field_next = record_field;
    res               = '0;
    res.kind          = KIND_CODE;

    if (parse_phase == PH_BYTES) begin
      items_left_next = items_dec;
      if (items_dec == 16'd0) begin
        parse_phase_next = PH_HEADER;
      end
    end else if (!byte_half) begin
      high_byte_next = byte_in;
      byte_half_next = 1'b1;
    end else begin
      byte_half_next = 1'b0;
      unique case (parse_phase)
        PH_ADDR: begin
          write_addr_next  = word[ADDR_BITS-1:0];
          parse_phase_next = PH_COUNT;
        end
        PH_COUNT: begin
          items_left_next = word;
          if (word == 16'd0) begin
            parse_phase_next = PH_HEADER;
          end else if (section_kind == SK_CODE || section_kind == SK_DATA) begin
            parse_phase_next = PH_PAYLOAD;
          end else begin
            parse_phase_next = PH_BYTES;
          end
        end
        PH_PAYLOAD: begin
          res.valid       = 1'b1;
          res.kind        = (section_kind == SK_DATA) ? KIND_DATA : KIND_CODE;
          res.mem_addr    = 16'(write_addr);
          res.mem_word    = word;
          write_addr_next = write_addr + 1'b1;
          items_left_next = items_dec;
          if (items_dec == 16'd0) begin
            parse_phase_next = PH_HEADER;
          end
        end
        PH_RECORD: begin
          record_field_next = field_inc;
          if (field_inc == LINE_REC_WORDS) begin
            record_field_next = 2'd0;
            parse_phase_next  = PH_HEADER;
          end
        end
        default: begin
          // header search
          priority if (word == HDR_CODE) begin
            section_kind_next = SK_CODE;
            parse_phase_next  = PH_ADDR;
          end else if (word == HDR_DATA) begin
            section_kind_next = SK_DATA;
            parse_phase_next  = PH_ADDR;
          end else if (word == HDR_SYMB) begin
            section_kind_next = SK_SYMB;
            parse_phase_next  = PH_ADDR;
          end else if (word == HDR_FILE) begin
            section_kind_next = SK_FILE;
            parse_phase_next  = PH_COUNT;
          end else if (word == HDR_LINE) begin
            section_kind_next = SK_LINE;
            record_field_next = 2'd0;
            parse_phase_next  = PH_RECORD;
          end else begin
            res.valid        = 1'b1;
            res.kind         = KIND_ERROR;
            res.mem_addr     = 16'd0;
            res.mem_word     = word;
            parse_phase_next = PH_HEADER;
          end
        end
      endcase
    end

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= PH_HEADER;
      byte_half    <= 1'b0;
      high_byte    <= 8'd0;
      section_kind <= SK_CODE;
      write_addr   <= '0;
      items_left   <= 16'd0;
      record_field <= 2'd0;
    end else if (step) begin
      parse_phase  <= parse_phase_next;
      byte_half    <= byte_half_next;
      high_byte    <= high_byte_next;
      section_kind <= section_kind_next;
      write_addr   <= write_addr_next;
      items_left   <= items_left_next;
      record_field <= record_field_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ofsl_out_reg.sv -----
// result register toward the memory write port
// depends on ofsl_pkg
`default_nettype none

module ofsl_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ofsl_pkg::result_t  res,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ofsl_pkg::kind_t         kind,
  output logic [15:0]             mem_addr,
  output logic [15:0]             mem_word
);

  import ofsl_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res.valid) begin
      kind     <= res.kind;
      mem_addr <= res.mem_addr;
      mem_word <= res.mem_word;
    end
  end

endmodule

`default_nettype wire
